/* rtl/hec_pkg.sv */
package hec_pkg;

	localparam int MAX_DATA_BITS = 16;
	localparam int DATA_W = MAX_DATA_BITS;
	localparam int KW = 5;

	function automatic int parity_count(input int k);
		int r;
		r = 1;
		for (int i = 0; i < 8; i++) begin
			if ((1 << r) < k + r + 1) begin
				r++;
			end
		end
		return r;
	endfunction

	localparam int CODE_W = MAX_DATA_BITS + parity_count(MAX_DATA_BITS);
	localparam int SYN_W = $clog2(CODE_W + 1);
	localparam int RES_W = CODE_W + DATA_W + SYN_W + 2;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int IN_DATA_W = DATA_W + CODE_W;
	localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_CHECK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAN = 2'd0,
		ST_FIXED = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] cw;
		logic [SYN_W-1:0]  n;
	} code_t;

	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] cw;
		logic [SYN_W-1:0]  n;
		logic [SYN_W-1:0]  syn;
	} synd_t;

	typedef struct packed {
		status_t           status;
		logic [SYN_W-1:0]  syndrome;
		logic [DATA_W-1:0] data_out;
		logic [CODE_W-1:0] code_word;
	} result_t;

	function automatic logic is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// codeword length for k data bits
	function automatic logic [SYN_W-1:0] code_len(input int k);
		return SYN_W'(k + parity_count(k));
	endfunction

	// place data bits at the positions that are not powers of two
	function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] d);
		logic [CODE_W-1:0] cw;
		int idx;
		cw = '0;
		idx = 0;
		for (int p = 1; p <= CODE_W; p++) begin
			if (!is_pow2(p)) begin
				if (idx < DATA_W) begin
					cw[p-1] = d[idx];
				end
				idx++;
			end
		end
		return cw;
	endfunction

	function automatic logic [DATA_W-1:0] gather(input logic [CODE_W-1:0] cw);
		logic [DATA_W-1:0] d;
		int idx;
		d = '0;
		idx = 0;
		for (int p = 1; p <= CODE_W; p++) begin
			if (!is_pow2(p)) begin
				if (idx < DATA_W) begin
					d[idx] = cw[p-1];
				end
				idx++;
			end
		end
		return d;
	endfunction

	// positions whose index has bit j set
	function automatic logic [CODE_W-1:0] pos_mask(input int j);
		logic [CODE_W-1:0] m;
		for (int p = 1; p <= CODE_W; p++) begin
			m[p-1] = ((p >> j) & 1) != 0;
		end
		return m;
	endfunction

endpackage

/* rtl/hec_map.sv */
module hec_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  hec_pkg::op_t                  op,
	input  logic [hec_pkg::DATA_W-1:0]    data_word,
	input  logic [hec_pkg::CODE_W-1:0]    received_word,
	input  logic [hec_pkg::KW-1:0]        data_bits,
	output logic                          valid_s1,
	output hec_pkg::code_t                code_s1
);

	logic [hec_pkg::KW-1:0]     k;
	logic [hec_pkg::SYN_W-1:0]  n;
	logic [hec_pkg::DATA_W-1:0] kmask;
	logic [hec_pkg::CODE_W-1:0] nmask;
	hec_pkg::code_t             code_d;

	always_comb begin
		if (data_bits == '0) begin
			k = hec_pkg::KW'(1);
		end else if (int'(data_bits) > hec_pkg::MAX_DATA_BITS) begin
			k = hec_pkg::KW'(hec_pkg::MAX_DATA_BITS);
		end else begin
			k = data_bits;
		end
		n = hec_pkg::code_len(int'(k));
		for (int i = 0; i < hec_pkg::DATA_W; i++) begin
			kmask[i] = i < int'(k);
		end
		for (int i = 0; i < hec_pkg::CODE_W; i++) begin
			nmask[i] = i < int'(n);
		end
		code_d.op = op;
		code_d.n  = n;
		if (op == hec_pkg::OP_ENCODE) begin
			code_d.cw = hec_pkg::scatter(data_word & kmask);
		end else begin
			code_d.cw = received_word & nmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			code_s1 <= code_d;
		end
	end

endmodule

/* rtl/hec_syn.sv */
module hec_syn (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  hec_pkg::code_t code_in,
	output logic           valid_s2,
	output hec_pkg::synd_t synd_s2
);

	hec_pkg::synd_t synd_d;

	// each syndrome bit is the parity of the positions carrying that bit
	always_comb begin
		synd_d.op = code_in.op;
		synd_d.cw = code_in.cw;
		synd_d.n  = code_in.n;
		for (int j = 0; j < hec_pkg::SYN_W; j++) begin
			synd_d.syn[j] = ^(code_in.cw & hec_pkg::pos_mask(j));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			synd_s2 <= synd_d;
		end
	end

endmodule

/* rtl/hec_fix.sv */
module hec_fix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  hec_pkg::synd_t   synd_in,
	output logic             valid_s3,
	output hec_pkg::result_t res_s3
);

	logic [hec_pkg::CODE_W-1:0] par;
	logic [hec_pkg::CODE_W-1:0] flip;
	logic [hec_pkg::CODE_W-1:0] cw;
	hec_pkg::status_t           st;
	hec_pkg::result_t           res_d;

	always_comb begin
		par = '0;
		for (int j = 0; j < hec_pkg::SYN_W; j++) begin
			if ((1 << j) <= hec_pkg::CODE_W) begin
				par[(1 << j) - 1] = synd_in.syn[j];
			end
		end
		if (synd_in.syn == '0) begin
			st = hec_pkg::ST_CLEAN;
		end else if (synd_in.syn <= synd_in.n) begin
			st = hec_pkg::ST_FIXED;
		end else begin
			st = hec_pkg::ST_RANGE;
		end
		for (int p = 1; p <= hec_pkg::CODE_W; p++) begin
			flip[p-1] = (st == hec_pkg::ST_FIXED) && (synd_in.syn == hec_pkg::SYN_W'(p));
		end
		if (synd_in.op == hec_pkg::OP_ENCODE) begin
			cw             = synd_in.cw | par;
			res_d.syndrome = '0;
			res_d.status   = hec_pkg::ST_CLEAN;
		end else begin
			cw             = synd_in.cw ^ flip;
			res_d.syndrome = synd_in.syn;
			res_d.status   = st;
		end
		res_d.code_word = cw;
		res_d.data_out  = hec_pkg::gather(cw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_s3 <= res_d;
		end
	end

endmodule

/* rtl/hamming_encode_and_check.sv */
// Hamming single-error-correcting encoder and checker, even parity, for 1 to 16
// data bits (cfg_data; 0 acts as 1, values above 16 act as 16; reset value 16).
// Parity bits sit at codeword positions 1, 2, 4, 8, 16; data fills the other
// positions upward from bit 0. A request with tuser 0 encodes data_word; with
// tuser 1 it checks received_word, flips the bit that the syndrome points at
// and returns the corrected codeword and its data, or flags status 2 when the
// syndrome lies beyond the codeword length. One request is taken every cycle
// unless back-pressure has filled the pipeline; each one passes through the
// stages mask and place, syndrome XOR tree, and correct and extract, the last
// stage being the output register. Each stage advances on its own when the
// stage after it is empty or moving, so bubbles close up under back-pressure.
// Write cfg_data only while no request is in flight.
module hamming_encode_and_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hec_pkg::KW-1:0]             cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// data_word[15:0], received_word[36:16], zero fill
	input  logic [hec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// opcode
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// code_word[20:0], data_out[36:21], syndrome[41:37], status[43:42], zero fill
	output logic [hec_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	logic [hec_pkg::KW-1:0] data_bits_q;

	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;
	hec_pkg::code_t   code_s1;
	hec_pkg::synd_t   synd_s2;
	hec_pkg::result_t res_s3;

	// hold the data width; write only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= hec_pkg::KW'(hec_pkg::MAX_DATA_BITS);
		end else if (cfg_we) begin
			data_bits_q <= cfg_data;
		end
	end

	// advance a stage when the one after it is empty or advancing
	assign en3 = !valid_s3 || m_axis_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign s_axis_tready = en1;

	hec_map u_map (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en1),
		.in_valid      (s_axis_tvalid),
		.op            (hec_pkg::op_t'(s_axis_tuser)),
		.data_word     (s_axis_tdata[hec_pkg::DATA_W-1:0]),
		.received_word (s_axis_tdata[hec_pkg::IN_DATA_W-1:hec_pkg::DATA_W]),
		.data_bits     (data_bits_q),
		.valid_s1      (valid_s1),
		.code_s1       (code_s1)
	);

	hec_syn u_syn (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.in_valid (valid_s1),
		.code_in  (code_s1),
		.valid_s2 (valid_s2),
		.synd_s2  (synd_s2)
	);

	hec_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.in_valid (valid_s2),
		.synd_in  (synd_s2),
		.valid_s3 (valid_s3),
		.res_s3   (res_s3)
	);

	// pack the result with code_word in the lowest bits, pad with zeros
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = hec_pkg::OUT_TDATA_W'(res_s3);

endmodule

/* rtl/hec_check.sv */
module hec_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [hec_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [hec_pkg::SYN_W-1:0] syn;
	logic [1:0]                st;

	assign syn = m_axis_tdata[hec_pkg::CODE_W+hec_pkg::DATA_W+:hec_pkg::SYN_W];
	assign st  = m_axis_tdata[hec_pkg::CODE_W+hec_pkg::DATA_W+hec_pkg::SYN_W+:2];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> st <= hec_pkg::ST_RANGE)
		else $error("undefined status code");

	a_clean_syn: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((st == hec_pkg::ST_CLEAN) == (syn == '0)))
		else $error("status disagrees with syndrome");

endmodule

bind hamming_encode_and_check hec_check u_hec_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* bench/hec_checker.sv */
package hec_tb_pkg;

	import hec_pkg::*;

	// clamp the register value to the width actually in use
	function automatic int eff_width(input logic [KW-1:0] kreg);
		int k;
		k = int'(kreg);
		if (k < 1) k = 1;
		if (k > MAX_DATA_BITS) k = MAX_DATA_BITS;
		return k;
	endfunction

	function automatic int check_bits(input int k);
		int r;
		r = 1;
		while ((1 << r) < k + r + 1) r++;
		return r;
	endfunction

	function automatic int code_length(input logic [KW-1:0] kreg);
		int k;
		k = eff_width(kreg);
		return k + check_bits(k);
	endfunction

	function automatic logic [SYN_W-1:0] position_xor(input logic [CODE_W-1:0] cw, input int n);
		logic [SYN_W-1:0] s;
		s = '0;
		for (int p = 1; p <= n; p++) begin
			if (cw[p-1]) s = s ^ SYN_W'(p);
		end
		return s;
	endfunction

	// expected outcome of one encode or check request at the given width
	function automatic result_t hamming_outcome(input op_t op, input logic [DATA_W-1:0] dw,
			input logic [CODE_W-1:0] rw, input logic [KW-1:0] kreg);
		int k, n, idx, flip;
		logic [CODE_W-1:0] cw;
		logic [DATA_W-1:0] d;
		logic [SYN_W-1:0] s;
		result_t res;
		k = eff_width(kreg);
		n = k + check_bits(k);
		cw = '0;
		d = '0;
		res = '0;
		res.status = ST_CLEAN;
		if (op == OP_ENCODE) begin
			idx = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					cw[p-1] = dw[idx];
					d[idx] = dw[idx];
					idx++;
				end
			end
			// with the check bits still clear, the syndrome equals their values
			s = position_xor(cw, n);
			for (int j = 0; j < SYN_W; j++) begin
				if (s[j]) cw[(1 << j) - 1] = 1'b1;
			end
			res.syndrome = '0;
		end else begin
			for (int p = 0; p < n; p++) cw[p] = rw[p];
			s = position_xor(cw, n);
			if (s == '0) begin
				res.status = ST_CLEAN;
			end else if (int'(s) <= n) begin
				flip = int'(s) - 1;
				cw[flip] = ~cw[flip];
				res.status = ST_FIXED;
			end else begin
				res.status = ST_RANGE;
			end
			idx = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					d[idx] = cw[p-1];
					idx++;
				end
			end
			res.syndrome = s;
		end
		res.code_word = cw;
		res.data_out = d;
		return res;
	endfunction

endpackage

module hec_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hec_pkg::KW-1:0]         cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [hec_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [hec_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                             fail_count,
	output int                             pending_count
);

	import hec_pkg::*;
	import hec_tb_pkg::*;

	result_t outcomes_due[$];
	logic [KW-1:0] width_reg;

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			width_reg = KW'(MAX_DATA_BITS);
			outcomes_due.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[RES_W-1:0]);
				if (outcomes_due.size() == 0) begin
					$error("result with none outstanding: %0h", m_axis_tdata);
					fail_count++;
				end else begin
					want = outcomes_due.pop_front();
					check_field("code_word", want.code_word, got.code_word);
					check_field("data_out", want.data_out, got.data_out);
					check_field("syndrome", want.syndrome, got.syndrome);
					check_field("status", want.status, got.status);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				outcomes_due.push_back(hamming_outcome(op_t'(s_axis_tuser),
					s_axis_tdata[DATA_W-1:0], s_axis_tdata[IN_DATA_W-1:DATA_W], width_reg));
			end
			if (cfg_we) width_reg = cfg_data;
			pending_count = outcomes_due.size();
		end
	end

endmodule

/* bench/hamming_encode_and_check_tb.sv */
module hamming_encode_and_check_tb;

	import hec_pkg::*;
	import hec_tb_pkg::*;

	// run length guard: far above the slowest legal run
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_REQUESTS = 106;
	localparam int HOLD_OFF_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [KW-1:0]          cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending_count;
	int cycle_count;

	// our own copy of the width register, used to shape the stimulus
	logic [KW-1:0] width_now;

	// idling knobs, in percent, changed per phase
	int tx_gap_pct;
	int rx_stall_pct;

	// long receiver hold-offs: main process asks, receiver process serves
	int hold_offs_asked;
	int hold_offs_done;
	int rx_hold_left;

	int phase_width [RANDOM_PHASES] = '{16, 1, 8, 31, 0, 11, 5, 17, 2, 13, 26, 4, 16};

	hamming_encode_and_check DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hec_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int idle_length(input int pct);
		if ($urandom_range(99) >= pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [CODE_W-1:0] codeword_of(input logic [DATA_W-1:0] d);
		result_t enc;
		enc = hamming_outcome(OP_ENCODE, d, '0, width_now);
		return enc.code_word;
	endfunction

	// Offer one request and hold it until accepted. Call at a falling edge;
	// return at the falling edge after acceptance with tvalid dropped, so a
	// following call can raise it again in the same step without a glitch.
	task automatic push_request(input op_t op, input logic [DATA_W-1:0] dw,
			input logic [CODE_W-1:0] rw);
		int gap;
		gap = idle_length(tx_gap_pct);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = '0;
		s_axis_tdata[DATA_W-1:0] = dw;
		s_axis_tdata[IN_DATA_W-1:DATA_W] = rw;
		s_axis_tuser = op;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Write the width register once the pipeline has drained.
	task automatic set_width(input logic [KW-1:0] k);
		while (pending_count != 0) @(negedge clk);
		// let the three pipeline stages settle before touching the register
		repeat (4) @(negedge clk);
		cfg_data = k;
		cfg_we = 1'b1;
		width_now = k;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// One random request: mostly encodes and checks of real codewords with
	// zero, one or two flipped bits, the rest raw noise.
	task automatic random_request();
		int n, roll, b0, b1;
		logic [DATA_W-1:0] dw;
		logic [CODE_W-1:0] rw, cw, above;
		n = code_length(width_now);
		dw = DATA_W'($urandom);
		rw = CODE_W'($urandom);
		roll = $urandom_range(99);
		if (roll < 35) begin
			push_request(OP_ENCODE, dw, rw);
		end else begin
			cw = codeword_of(dw);
			// garbage above the codeword length must be ignored
			above = rw & ~((CODE_W'(1) << n) - CODE_W'(1));
			if ($urandom_range(1) == 1) cw = cw | above;
			b0 = $urandom_range(n - 1);
			b1 = $urandom_range(n - 1);
			if (roll >= 60 && roll < 85) begin
				cw[b0] = ~cw[b0];
			end else if (roll >= 85 && roll < 93) begin
				cw[b0] = ~cw[b0];
				cw[b1] = ~cw[b1];
			end else if (roll >= 93) begin
				cw = rw;
			end
			push_request(OP_CHECK, DATA_W'($urandom), cw);
		end
	endtask

	// Receiver: drive tready at falling edges. Serve a long hold-off when
	// asked, otherwise stall at random per the current knob.
	initial begin
		m_axis_tready = 1'b0;
		rx_hold_left = 0;
		hold_offs_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_axis_tready = 1'b0;
				rx_hold_left--;
			end else if (hold_offs_asked > hold_offs_done) begin
				hold_offs_done++;
				rx_hold_left = HOLD_OFF_CYCLES - 1;
				m_axis_tready = 1'b0;
			end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
				rx_hold_left = idle_length(100) - 1;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin
		logic [CODE_W-1:0] cw;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ENCODE;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		hold_offs_asked = 0;
		cycle_count = 0;
		width_now = KW'(MAX_DATA_BITS);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset width, full 16 data bits
		push_request(OP_ENCODE, 16'h0000, '0);
		push_request(OP_ENCODE, 16'hFFFF, '0);
		push_request(OP_ENCODE, 16'h8001, '0);
		push_request(OP_ENCODE, 16'h5A5A, '0);
		push_request(OP_CHECK, '0, '0);
		push_request(OP_CHECK, '0, 21'h1FFFFF);
		cw = codeword_of(16'hFFFF);
		cw[CODE_W-1] = ~cw[CODE_W-1];
		push_request(OP_CHECK, '0, cw);
		cw = codeword_of(16'h1234);
		cw[0] = ~cw[0];
		push_request(OP_CHECK, '0, cw);
		// positions 8 and 16: syndrome 24 lies beyond the 21-bit codeword
		push_request(OP_CHECK, '0, 21'h008080);

		// zero width acts as one data bit
		set_width('0);
		push_request(OP_ENCODE, 16'hFFFF, '0);
		push_request(OP_CHECK, '0, 21'h1FFFFF);
		push_request(OP_CHECK, '0, 21'h1FFFFC);

		// width above the maximum acts as the maximum
		set_width('1);
		push_request(OP_ENCODE, 16'hFFFF, '0);
		push_request(OP_CHECK, '0, 21'h0800AA);

		// two data bits, five positions: syndrome beyond length is reachable
		set_width(KW'(2));
		push_request(OP_CHECK, '0, 21'h00000C);
		push_request(OP_ENCODE, 16'hFFFE, 21'h1FFFFF);
		cw = codeword_of(16'h0003);
		cw[4] = ~cw[4];
		push_request(OP_CHECK, '0, cw | 21'h1FFFE0);

		// four data bits: unused data and codeword bits ignored
		set_width(KW'(4));
		push_request(OP_ENCODE, 16'hFFF5, '0);
		push_request(OP_CHECK, '0, 21'h1FFF80);
		cw = codeword_of(16'h000A);
		cw[2] = ~cw[2];
		push_request(OP_CHECK, '0, cw | 21'h155500);

		// random phases, one width each, idling varied per phase
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_width(KW'(phase_width[ph]));
			if (ph % 4 == 3) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct = $urandom_range(10, 50);
				rx_stall_pct = $urandom_range(10, 50);
			end
			// keep offering back to back while the receiver holds off
			if (ph == 2 || ph == 9) begin
				tx_gap_pct = 0;
				hold_offs_asked++;
			end
			repeat (PHASE_REQUESTS) random_request();
		end

		// drain, then allow the pipeline latency to pass
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* hamming_encode_and_check.f */
rtl/hec_pkg.sv
rtl/hec_map.sv
rtl/hec_syn.sv
rtl/hec_fix.sv
rtl/hamming_encode_and_check.sv
rtl/hec_check.sv
bench/hec_checker.sv
bench/hamming_encode_and_check_tb.sv
